// ----- design/apu_pkg.sv -----
// ----------------------------------------------------------------------------
// apu_pkg - shared types, constants and round function
// Word and count widths, the controller state type, the command bundle that
// the controller sends to the datapath, and the combinational Ascon round.
// ----------------------------------------------------------------------------
package apu_pkg;

	localparam int unsigned WordW    = 64;
	localparam int unsigned NumWords = 5;
	localparam int unsigned CountW   = 4;
	localparam int unsigned RcW      = 8;
	localparam int unsigned StateW   = WordW * NumWords;
	// five words plus round count, padded to whole bytes
	localparam int unsigned InDataW  = ((StateW + CountW + 7) / 8) * 8;
	localparam int unsigned OutDataW = StateW;

	localparam logic [CountW-1:0] MaxRounds = 4'd12;
	localparam logic [RcW-1:0]    RcBase    = 8'd60;
	localparam logic [RcW-1:0]    RcStep    = 8'd15;

	// word 0 in the lowest bits
	typedef logic [NumWords-1:0][WordW-1:0] state_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} ctrl_state_t;

	typedef struct packed {
		logic load;   // capture input transaction
		logic round;  // apply one round to the working state
		logic xfer;   // move working state to the output register
	} dp_cmd_t;

	// counts above the full permutation saturate
	function automatic logic [CountW-1:0] sat_rounds(input logic [CountW-1:0] n);
		return (n > MaxRounds) ? MaxRounds : n;
	endfunction

	// first constant: base plus fifteen times the count
	function automatic logic [RcW-1:0] first_rc(input logic [CountW-1:0] n);
		logic [RcW-1:0] n_w;
		n_w = {{(RcW-CountW){1'b0}}, n};
		return RcBase + (n_w << 4) - n_w;
	endfunction

	function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] v,
		input int unsigned r);
		return (v >> r) | (v << (WordW - r));
	endfunction

	// constant addition, bitsliced S-box, linear diffusion
	function automatic state_t apply_round(input state_t s, input logic [RcW-1:0] rc);
		logic [WordW-1:0] a0, a1, a2, a3, a4;
		logic [WordW-1:0] n0, n1, n2, n3, n4;
		state_t r;
		a0 = s[0] ^ s[4];
		a4 = s[4] ^ s[3];
		a2 = s[2] ^ {{(WordW-RcW){1'b0}}, rc} ^ s[1];
		a1 = s[1];
		a3 = s[3];
		n0 = ~a0 & a1;
		n1 = ~a1 & a2;
		n2 = ~a2 & a3;
		n3 = ~a3 & a4;
		n4 = ~a4 & a0;
		a0 = a0 ^ n1;
		a1 = a1 ^ n2;
		a2 = a2 ^ n3;
		a3 = a3 ^ n4;
		a4 = a4 ^ n0;
		a1 = a1 ^ a0;
		a0 = a0 ^ a4;
		a3 = a3 ^ a2;
		a2 = ~a2;
		r[0] = a0 ^ rotr(a0, 19) ^ rotr(a0, 28);
		r[1] = a1 ^ rotr(a1, 61) ^ rotr(a1, 39);
		r[2] = a2 ^ rotr(a2, 1)  ^ rotr(a2, 6);
		r[3] = a3 ^ rotr(a3, 10) ^ rotr(a3, 17);
		r[4] = a4 ^ rotr(a4, 7)  ^ rotr(a4, 41);
		return r;
	endfunction

endpackage

// ----- design/apu_ctrl.sv -----
// ----------------------------------------------------------------------------
// apu_ctrl - sequencing controller
// Accepts a transaction, counts the rounds down and hands the finished state
// to the output register, tracking the output valid flag.
// ----------------------------------------------------------------------------
module apu_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [apu_pkg::CountW-1:0]  round_count,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output apu_pkg::dp_cmd_t            cmd
);
	import apu_pkg::*;

	ctrl_state_t       state_q, state_d;
	logic [CountW-1:0] count_q;
	logic              out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (cmd.xfer) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and datapath commands
	always_comb begin
		s_tready  = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_RUN: begin
				cmd.round = (count_q != '0);
				cmd.xfer  = (count_q == '0) && (!out_valid_q || m_tready);
			end
			default: ;
		endcase
	end

	// rounds remaining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load) begin
			count_q <= sat_rounds(round_count);
		end else if (cmd.round) begin
			count_q <= count_q - 1'b1;
		end
	end

	// output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MaxRounds)
		else $error("round counter beyond full permutation");
	a_load_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_RUN) && !s_tready)
		else $error("accepted transaction did not start a run");
	a_xfer_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.xfer |=> m_tvalid)
		else $error("transfer did not raise output valid");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !cmd.xfer)
		else $error("pending result overwritten");
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.round, cmd.xfer}))
		else $error("conflicting datapath commands");

endmodule

// ----- design/apu_datapath.sv -----
// ----------------------------------------------------------------------------
// apu_datapath - working state, round constant and output register
// One Ascon round per cycle on the working state; result held in a separate
// output register so a new transaction can start while it waits.
// ----------------------------------------------------------------------------
module apu_datapath (
	input  logic                         clk,
	input  apu_pkg::dp_cmd_t             cmd,
	input  logic [apu_pkg::InDataW-1:0]  s_tdata,
	output logic [apu_pkg::OutDataW-1:0] m_tdata
);
	import apu_pkg::*;

	state_t            state_q;
	state_t            out_q;
	logic [RcW-1:0]    rc_q;
	logic [CountW-1:0] in_count;

	assign in_count = s_tdata[StateW +: CountW];

	// working state and round constant
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			state_q <= state_t'(s_tdata[StateW-1:0]);
			rc_q    <= first_rc(sat_rounds(in_count));
		end else if (cmd.round) begin
			state_q <= apply_round(state_q, rc_q);
			rc_q    <= rc_q - RcStep;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.xfer) begin
			out_q <= state_q;
		end
	end

	assign m_tdata = out_q;

endmodule

// ----- design/ascon_permutation_unit.sv -----
// ----------------------------------------------------------------------------
// ascon_permutation_unit - last n rounds of the Ascon permutation
// Top level: stream ports, controller and datapath.
// ----------------------------------------------------------------------------
// A transaction carries the five 64-bit state words and a round count n; the
// unit applies the last n rounds of the 12-round Ascon permutation (counts
// above 12 act as 12, a count of 0 returns the state unchanged). One round is
// computed per clock in a single round unit. The state is loaded at the
// accepting edge and updated by each round until the count reaches zero;
// it then moves into the output register, which raises the output valid.
// The unit takes one transaction at a time; the next is accepted the cycle
// after the previous result has moved into the output register, even if it
// has not been taken. A result still waiting in the output register delays
// that move, and with it the next acceptance.
module ascon_permutation_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// in_word0..in_word4 (64 each), round_count (4), zero pad (4)
	input  logic [apu_pkg::InDataW-1:0]  s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// out_word0..out_word4 (64 each)
	output logic [apu_pkg::OutDataW-1:0] m_tdata
);
	import apu_pkg::*;

	dp_cmd_t cmd;

	// sequencing
	apu_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.round_count (s_tdata[StateW +: CountW]),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.cmd         (cmd)
	);

	// round datapath
	apu_datapath u_datapath (
		.clk     (clk),
		.cmd     (cmd),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata)
	);

endmodule

// ----- bench/ascon_permutation_unit_tb.sv -----
// ----------------------------------------------------------------------------
// ascon_permutation_unit_tb - self-checking bench for the permutation unit
// Drives state words and round counts into the input stream and checks every
// output transaction against a hand-written result or a local model of the
// final Ascon rounds. Directed cases from a short table come first, then
// random phases, most with random gaps and back-pressure on both streams.
// ----------------------------------------------------------------------------
module ascon_permutation_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned  WordBits   = 64;
	localparam int unsigned  WordCount  = 5;
	localparam int unsigned  FullRounds = 12;
	localparam logic [63:0]  RcStart    = 64'd60;
	localparam logic [63:0]  RcDrop     = 64'd15;
	localparam int unsigned  RandItems  = 1530;
	localparam int unsigned  NumPhases  = 6;
	localparam int unsigned  DrainWait  = 20;
	localparam int unsigned  MaxReports = 10;
	localparam longint       RunLimitNs = 2_000_000;

	typedef logic [WordCount-1:0][WordBits-1:0] words_t;

	// one directed case; typed rows carry their result written out by hand
	typedef struct {
		words_t     state;
		logic [3:0] rounds;
		bit         typed;
		words_t     result;
	} stim_row_t;

	logic                         clk;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	// in_word0..in_word4 (64 each), round_count (4), zero pad (4)
	logic [apu_pkg::InDataW-1:0]  s_tdata = '0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	// out_word0..out_word4 (64 each)
	logic [apu_pkg::OutDataW-1:0] m_tdata;

	words_t    pending_states[$];
	stim_row_t stim_rows[$];
	int        mismatches = 0;
	int        results_seen = 0;
	bit        calm = 1'b0;
	int        sink_hold = 0;

	ascon_permutation_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard limit on run time
	initial begin
		#(RunLimitNs);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [63:0] ror64(input logic [63:0] v, input int unsigned r);
		return (v >> r) | (v << (WordBits - r));
	endfunction

	// last n rounds of the permutation; counts above twelve act as twelve
	function automatic words_t permute_tail(input words_t s_in, input logic [3:0] cnt);
		words_t      s;
		logic [63:0] t0, t1, t2, t3, t4;
		logic [63:0] c0, c1, c2, c3, c4;
		logic [63:0] rc;
		int unsigned n;
		s  = s_in;
		n  = (cnt > FullRounds) ? FullRounds : cnt;
		rc = RcStart + RcDrop * n;
		for (int unsigned k = 0; k < n; k++) begin
			// constant addition folded into the S-box input
			t0 = s[0] ^ s[4];
			t4 = s[4] ^ s[3];
			t2 = s[2] ^ rc ^ s[1];
			t1 = s[1];
			t3 = s[3];
			c0 = ~t0 & t1;
			c1 = ~t1 & t2;
			c2 = ~t2 & t3;
			c3 = ~t3 & t4;
			c4 = ~t4 & t0;
			t0 ^= c1;
			t1 ^= c2;
			t2 ^= c3;
			t3 ^= c4;
			t4 ^= c0;
			t1 ^= t0;
			t0 ^= t4;
			t3 ^= t2;
			t2 = ~t2;
			// linear diffusion
			s[0] = t0 ^ ror64(t0, 19) ^ ror64(t0, 28);
			s[1] = t1 ^ ror64(t1, 61) ^ ror64(t1, 39);
			s[2] = t2 ^ ror64(t2, 1)  ^ ror64(t2, 6);
			s[3] = t3 ^ ror64(t3, 10) ^ ror64(t3, 17);
			s[4] = t4 ^ ror64(t4, 7)  ^ ror64(t4, 41);
			rc -= RcDrop;
		end
		return s;
	endfunction

	// mostly short idles, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else begin
			return $urandom_range(4, 30);
		end
	endfunction

	// random word with the odd all-zero or all-one value
	function automatic logic [63:0] rand_word();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			return '0;
		end else if (r == 1) begin
			return '1;
		end else begin
			return {$urandom(), $urandom()};
		end
	endfunction

	// mostly legal counts, with zero and the saturating ones mixed in
	function automatic logic [3:0] rand_rounds();
		if ($urandom_range(0, 9) == 0) begin
			return ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
		end else begin
			return 4'($urandom_range(1, 12));
		end
	endfunction

	function automatic void add_row(input words_t st, input logic [3:0] n,
		input bit typed, input words_t res);
		stim_row_t row;
		row.state  = st;
		row.rounds = n;
		row.typed  = typed;
		row.result = res;
		stim_rows.push_back(row);
	endfunction

	// present one transaction and wait for it to be taken
	task automatic push_state(input words_t st, input logic [3:0] n, input words_t want);
		int gap;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0000, n, st};
		do @(posedge clk); while (!s_tready);
		pending_states.push_back(want);
	endtask

	task automatic wait_drained();
		while (pending_states.size() != 0) @(posedge clk);
	endtask

	// compare one output transaction with the oldest expected state
	task automatic check_result(input words_t got);
		words_t want;
		results_seen++;
		if (pending_states.size() == 0) begin
			if (mismatches < MaxReports)
				$display("[%0t] result %0d with no transaction pending: %h",
					$realtime, results_seen, got);
			mismatches++;
		end else begin
			want = pending_states.pop_front();
			for (int w = 0; w < WordCount; w++) begin
				if (got[w] !== want[w]) begin
					if (mismatches < MaxReports)
						$display("[%0t] result %0d word %0d: expected %h, got %h",
							$realtime, results_seen, w, want[w], got[w]);
					mismatches++;
				end
			end
		end
	endtask

	// output side: check and, outside calm phases, apply random back-pressure
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result(m_tdata);
		if (calm || !arst_n) begin
			m_tready <= arst_n;
		end else if (sink_hold > 0) begin
			m_tready <= 1'b0;
			sink_hold--;
		end else begin
			m_tready <= 1'b1;
			sink_hold = pick_gap();
		end
	end

	// stimulus
	initial begin
		words_t st;
		words_t mixed;
		logic [3:0] n;

		mixed = {64'h0123456789abcdef, 64'hfedcba9876543210, 64'h00000000000000ff,
			64'hdeadbeefcafef00d, 64'h80400c0600000000};

		// zero count returns the state as it came in
		add_row('0, 4'd0, 1'b1, '0);
		add_row('1, 4'd0, 1'b1, '1);
		add_row(mixed, 4'd0, 1'b1, mixed);
		// extremes of the state and of the count, including saturation
		add_row('0, 4'd1, 1'b0, '0);
		add_row('0, 4'd12, 1'b0, '0);
		add_row('0, 4'd13, 1'b0, '0);
		add_row('0, 4'd15, 1'b0, '0);
		add_row('1, 4'd1, 1'b0, '0);
		add_row('1, 4'd12, 1'b0, '0);
		add_row('1, 4'd14, 1'b0, '0);
		add_row({5{64'haaaaaaaaaaaaaaaa}}, 4'd6, 1'b0, '0);
		add_row({5{64'h5555555555555555}}, 4'd7, 1'b0, '0);
		add_row({256'd0, 64'd1}, 4'd12, 1'b0, '0);
		add_row({64'h8000000000000000, 256'd0}, 4'd12, 1'b0, '0);
		add_row({128'd0, 64'h00000000000000ff, 128'd0}, 4'd1, 1'b0, '0);
		add_row(mixed, 4'd12, 1'b0, '0);
		// every remaining round count
		for (int k = 2; k <= 11; k++)
			add_row(mixed, 4'(k), 1'b0, '0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (stim_rows[i]) begin
			push_state(stim_rows[i].state, stim_rows[i].rounds,
				stim_rows[i].typed ? stim_rows[i].result
					: permute_tail(stim_rows[i].state, stim_rows[i].rounds));
		end

		// random phases; each opens with the sender held until all results are in
		for (int p = 0; p < NumPhases; p++) begin
			s_tvalid <= 1'b0;
			wait_drained();
			@(posedge clk);
			calm = (p % 3 == 1);
			for (int i = 0; i < RandItems / NumPhases; i++) begin
				for (int w = 0; w < WordCount; w++)
					st[w] = rand_word();
				n = rand_rounds();
				push_state(st, n, permute_tail(st, n));
			end
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		// drain and let any stray result show up
		wait_drained();
		repeat (DrainWait) @(posedge clk);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
